### design/drse_pkg.sv
// drse_pkg: shared types and constants for the disjoint range set engine.
// No dependencies.
package drse_pkg;

    localparam int unsigned VAL_W  = 32;
    localparam int unsigned IDX_W  = 6;
    localparam int unsigned SCNT_W = 7;
    localparam int unsigned WORD_W = 2 * VAL_W;

    typedef enum logic [2:0] {
        OP_ADD   = 3'd0,
        OP_SUB   = 3'd1,
        OP_INTER = 3'd2,
        OP_POINT = 3'd3,
        OP_RANGE = 3'd4,
        OP_SHUP  = 3'd5,
        OP_SHDN  = 3'd6,
        OP_READ  = 3'd7
    } t_op;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_FULL = 2'd1,
        ST_BAD  = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ISSUE,
        S_PROC,
        S_EMIT2,
        S_FIN,
        S_DONE
    } t_state;

    typedef struct packed {
        t_op                 op;
        logic [VAL_W-1:0]    seg_low;
        logic [VAL_W-1:0]    seg_high;
        logic [VAL_W-1:0]    value_arg;
        logic [IDX_W-1:0]    entry_index;
    } t_req;

    typedef struct packed {
        t_status             status;
        logic                hit;
        logic                entry_valid;
        logic [VAL_W-1:0]    entry_low;
        logic [VAL_W-1:0]    entry_high;
        logic [SCNT_W-1:0]   segment_count;
    } t_result;

endpackage

### design/disjoint_range_set_engine.sv
// disjoint_range_set_engine: top level, input capture and output register.
// Depends on drse_pkg, drse_ctrl.
//
// Holds a sorted table of disjoint inclusive 32-bit ranges in one double-banked
// memory. Every update reads the live bank entry by entry (registered read port)
// and writes the new table into the other bank, then flips banks; a full table
// leaves the old bank live. The walk takes each stored entry through an issue
// state and a process state, plus an emit state per split or inserted entry.
// A new item is taken while the previous result still waits in the output register.
module disjoint_range_set_engine #(
    parameter int unsigned MAX_SEGMENTS = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [2:0]  i_req_type,
    input  logic [31:0] i_seg_low,
    input  logic [31:0] i_seg_high,
    input  logic [31:0] i_value_arg,
    input  logic [5:0]  i_entry_index,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_status,
    output logic        o_hit,
    output logic        o_entry_valid,
    output logic [31:0] o_entry_low,
    output logic [31:0] o_entry_high,
    output logic [6:0]  o_segment_count
);

    drse_pkg::t_req    req;
    drse_pkg::t_result res, r_out;
    logic              busy, res_valid, take, start;
    logic              r_out_valid;

    assign req.op          = drse_pkg::t_op'(i_req_type);
    assign req.seg_low     = i_seg_low;
    assign req.seg_high    = i_seg_high;
    assign req.value_arg   = i_value_arg;
    assign req.entry_index = i_entry_index;

    assign o_in_stall = busy;
    assign start      = i_in_valid && !busy;
    assign take       = res_valid && (!r_out_valid || !i_out_stall);

    drse_ctrl #(.MAX_SEGMENTS(MAX_SEGMENTS)) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .i_req      (req),
        .o_busy     (busy),
        .o_res_valid(res_valid),
        .i_res_take (take),
        .o_res      (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (take) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
        if (take) begin
            r_out <= res;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_status        = r_out.status;
    assign o_hit           = r_out.hit;
    assign o_entry_valid   = r_out.entry_valid;
    assign o_entry_low     = r_out.entry_low;
    assign o_entry_high    = r_out.entry_high;
    assign o_segment_count = r_out.segment_count;

endmodule

### design/drse_ram.sv
// drse_ram: one write port, one registered read port.
// No dependencies.
module drse_ram #(
    parameter int unsigned ADDR_W = 7,
    parameter int unsigned DATA_W = 64
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] mem [2**ADDR_W];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### design/drse_ctrl.sv
// drse_ctrl: sequencer that walks the table bank, rebuilds it into the other bank.
// Depends on drse_pkg, drse_ram.
module drse_ctrl #(
    parameter int unsigned MAX_SEGMENTS = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  drse_pkg::t_req    i_req,
    output logic              o_busy,
    output logic              o_res_valid,
    input  logic              i_res_take,
    output drse_pkg::t_result o_res
);

    localparam int unsigned AW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
    localparam int unsigned CW = $clog2(MAX_SEGMENTS + 2);
    localparam int unsigned VW = drse_pkg::VAL_W;
    localparam logic [CW-1:0] MAXC = CW'(MAX_SEGMENTS);

    drse_pkg::t_state  r_state, n_state;
    drse_pkg::t_op     r_op, n_op;
    drse_pkg::t_status r_status, n_status;
    logic [VW-1:0]     r_lo, n_lo, r_hi, n_hi, r_val, n_val;
    logic [drse_pkg::IDX_W-1:0] r_idx, n_idx;
    logic              r_bank, n_bank;
    logic [CW-1:0]     r_count, n_count, r_i, n_i, r_w, n_w;
    logic              r_placed, n_placed, r_hit, n_hit, r_rdv, n_rdv;
    logic [VW-1:0]     r_elo, n_elo, r_ehi, n_ehi;
    logic [drse_pkg::WORD_W-1:0] r_e2, n_e2;

    logic                        we;
    logic [AW:0]                 waddr, raddr;
    logic [drse_pkg::WORD_W-1:0] wdata, rdata;
    logic [VW-1:0]               a, b, ca, cb;
    logic [VW:0]                 sa, sb;
    logic                        e1v, e2v;
    logic [drse_pkg::WORD_W-1:0] e1, e2;
    logic [CW-1:0]               fc;
    logic                        bad;

    drse_ram #(.ADDR_W(AW + 1), .DATA_W(drse_pkg::WORD_W)) u_ram (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(waddr),
        .i_wdata(wdata),
        .i_raddr(raddr),
        .o_rdata(rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= drse_pkg::S_IDLE;
            r_bank  <= 1'b0;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_bank  <= n_bank;
            r_count <= n_count;
        end
        r_op     <= n_op;
        r_status <= n_status;
        r_lo     <= n_lo;
        r_hi     <= n_hi;
        r_val    <= n_val;
        r_idx    <= n_idx;
        r_i      <= n_i;
        r_w      <= n_w;
        r_placed <= n_placed;
        r_hit    <= n_hit;
        r_rdv    <= n_rdv;
        r_elo    <= n_elo;
        r_ehi    <= n_ehi;
        r_e2     <= n_e2;
    end

    assign a  = rdata[drse_pkg::WORD_W-1:VW];
    assign b  = rdata[VW-1:0];
    assign sa = {1'b0, a} + {1'b0, r_val};
    assign sb = {1'b0, b} + {1'b0, r_val};
    assign ca = (a < r_lo) ? r_lo : a;
    assign cb = (b > r_hi) ? r_hi : b;
    assign fc = r_w + CW'((r_op == drse_pkg::OP_ADD) && !r_placed);
    assign bad = (i_req.op == drse_pkg::OP_ADD || i_req.op == drse_pkg::OP_SUB ||
                  i_req.op == drse_pkg::OP_INTER || i_req.op == drse_pkg::OP_RANGE) &&
                 (i_req.seg_low > i_req.seg_high);

    // per-entry emits
    always_comb begin
        e1v = 1'b0;
        e2v = 1'b0;
        e1  = rdata;
        e2  = rdata;
        case (r_op)
            drse_pkg::OP_ADD: begin
                if (({1'b0, b} + 1'b1) < {1'b0, r_lo}) begin
                    e1v = 1'b1;
                end else if ({1'b0, a} > ({1'b0, r_hi} + 1'b1)) begin
                    if (!r_placed) begin
                        e1v = 1'b1;
                        e1  = {r_lo, r_hi};
                        e2v = 1'b1;
                    end else begin
                        e1v = 1'b1;
                    end
                end
            end
            drse_pkg::OP_SUB: begin
                if (b < r_lo || a > r_hi) begin
                    e1v = 1'b1;
                end else begin
                    if (a < r_lo) begin
                        e1v = 1'b1;
                        e1  = {a, r_lo - 1'b1};
                        if (b > r_hi) begin
                            e2v = 1'b1;
                            e2  = {r_hi + 1'b1, b};
                        end
                    end else if (b > r_hi) begin
                        e1v = 1'b1;
                        e1  = {r_hi + 1'b1, b};
                    end
                end
            end
            drse_pkg::OP_INTER: begin
                e1v = (ca <= cb);
                e1  = {ca, cb};
            end
            drse_pkg::OP_SHUP: begin
                e1v = !sa[VW];
                e1  = {sa[VW-1:0], sb[VW] ? {VW{1'b1}} : sb[VW-1:0]};
            end
            drse_pkg::OP_SHDN: begin
                e1v = (b >= r_val);
                e1  = {(a < r_val) ? {VW{1'b0}} : (a - r_val), b - r_val};
            end
            default: begin
                e1v = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_state  = r_state;
        n_op     = r_op;
        n_status = r_status;
        n_lo     = r_lo;
        n_hi     = r_hi;
        n_val    = r_val;
        n_idx    = r_idx;
        n_bank   = r_bank;
        n_count  = r_count;
        n_i      = r_i;
        n_w      = r_w;
        n_placed = r_placed;
        n_hit    = r_hit;
        n_rdv    = r_rdv;
        n_elo    = r_elo;
        n_ehi    = r_ehi;
        n_e2     = r_e2;
        we       = 1'b0;
        waddr    = {~r_bank, r_w[AW-1:0]};
        wdata    = e1;
        raddr    = {r_bank, r_i[AW-1:0]};
        case (r_state)
            drse_pkg::S_IDLE: begin
                if (i_start) begin
                    n_op     = i_req.op;
                    n_lo     = i_req.seg_low;
                    n_hi     = i_req.seg_high;
                    n_val    = i_req.value_arg;
                    n_idx    = i_req.entry_index;
                    n_i      = '0;
                    n_w      = '0;
                    n_placed = 1'b0;
                    n_hit    = 1'b0;
                    n_rdv    = 1'b0;
                    n_elo    = '0;
                    n_ehi    = '0;
                    n_status = bad ? drse_pkg::ST_BAD : drse_pkg::ST_OK;
                    n_state  = bad ? drse_pkg::S_DONE : drse_pkg::S_ISSUE;
                end
            end
            drse_pkg::S_ISSUE: begin
                if (r_op == drse_pkg::OP_READ) begin
                    raddr = {r_bank, AW'(r_idx)};
                    n_state = (32'(r_idx) < 32'(r_count)) ? drse_pkg::S_PROC
                                                          : drse_pkg::S_DONE;
                end else begin
                    n_state = (r_i < r_count) ? drse_pkg::S_PROC : drse_pkg::S_FIN;
                end
            end
            drse_pkg::S_PROC: begin
                n_i     = r_i + 1'b1;
                n_state = drse_pkg::S_ISSUE;
                case (r_op)
                    drse_pkg::OP_READ: begin
                        n_rdv   = 1'b1;
                        n_elo   = a;
                        n_ehi   = b;
                        n_state = drse_pkg::S_DONE;
                    end
                    drse_pkg::OP_POINT: begin
                        if (a <= r_val && r_val <= b) n_hit = 1'b1;
                    end
                    drse_pkg::OP_RANGE: begin
                        if (a <= r_lo && r_hi <= b) n_hit = 1'b1;
                    end
                    drse_pkg::OP_SHUP: begin
                        if (sa[VW]) n_state = drse_pkg::S_FIN;
                    end
                    drse_pkg::OP_ADD: begin
                        if (!(({1'b0, b} + 1'b1) < {1'b0, r_lo}) &&
                            !({1'b0, a} > ({1'b0, r_hi} + 1'b1))) begin
                            if (a < r_lo) n_lo = a;
                            if (b > r_hi) n_hi = b;
                        end
                        if (e2v) n_placed = 1'b1;
                    end
                    default: begin
                        n_hit = r_hit;
                    end
                endcase
                if (e1v) begin
                    we  = (r_w < MAXC);
                    n_w = r_w + 1'b1;
                end
                if (e2v) begin
                    n_e2    = e2;
                    n_state = drse_pkg::S_EMIT2;
                end
            end
            drse_pkg::S_EMIT2: begin
                we      = (r_w < MAXC);
                wdata   = r_e2;
                n_w     = r_w + 1'b1;
                n_state = drse_pkg::S_ISSUE;
            end
            drse_pkg::S_FIN: begin
                wdata = {r_lo, r_hi};
                we    = (r_op == drse_pkg::OP_ADD) && !r_placed && (r_w < MAXC);
                if (r_op == drse_pkg::OP_ADD || r_op == drse_pkg::OP_SUB ||
                    r_op == drse_pkg::OP_INTER || r_op == drse_pkg::OP_SHUP ||
                    r_op == drse_pkg::OP_SHDN) begin
                    if (fc > MAXC) begin
                        n_status = drse_pkg::ST_FULL;
                    end else begin
                        n_bank  = ~r_bank;
                        n_count = fc;
                    end
                end
                n_state = drse_pkg::S_DONE;
            end
            drse_pkg::S_DONE: begin
                if (i_res_take) n_state = drse_pkg::S_IDLE;
            end
            default: begin
                n_state = drse_pkg::S_IDLE;
            end
        endcase
    end

    assign o_busy      = (r_state != drse_pkg::S_IDLE);
    assign o_res_valid = (r_state == drse_pkg::S_DONE);

    always_comb begin
        o_res.status        = r_status;
        o_res.hit           = r_hit;
        o_res.entry_valid   = r_rdv;
        o_res.entry_low     = r_elo;
        o_res.entry_high    = r_ehi;
        o_res.segment_count = drse_pkg::SCNT_W'(32'(r_count));
    end

endmodule
